// File: rtl/vtpd_pkg.sv
// Shared constants for the vertex transform and perspective divide block.
`default_nettype none
package vtpd_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_TRANSFORM = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_WZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage
`default_nettype wire

// File: rtl/vtpd_div_step.sv
// One restoring division step: shift in one numerator bit, compare, subtract.
`default_nettype none
module vtpd_div_step #(
  parameter int MW = 50
) (
  input  wire logic [MW-1:0] rem_in,
  input  wire logic [MW-1:0] den,
  input  wire logic          bit_in,
  output logic      [MW-1:0] rem_out,
  output logic               q_bit
);

  logic [MW:0] trial;
  logic [MW:0] diff;

  always_comb begin
    trial   = {rem_in, bit_in};
    diff    = trial - {1'b0, den};
    q_bit   = (trial >= {1'b0, den});
    // remainder stays below the divisor, so the top bit drops
    rem_out = q_bit ? diff[MW-1:0] : trial[MW-1:0];
  end

endmodule
`default_nettype wire

// File: rtl/vertex_transform_perspective_divide.sv
// Top level: 4x4 homogeneous point transform with pipelined perspective divide.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid, in_stall, action, element_index,    | request in
//          | element_value, point_x, point_y, point_z      |
//  output  | out_valid, out_stall, out_x, out_y, out_z,    | request out
//          | status                                        |
//
// One request per clock while in_stall is low. A transform request passes 39
// register stages, the last of which drives out_valid: capture, products, two summing
// stages, magnitude, range check, 32 restoring divide stages (one quotient bit
// each), and the output register.
// A load request writes the matrix at acceptance and leaves no result.
// Synchronous reset empties the pipeline and loads the identity matrix.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles squeeze out under out_stall and in_stall rises only when all fill.
`default_nettype none
module vertex_transform_perspective_divide
  import vtpd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic        [3:0]  element_index,
  input  wire logic signed [31:0] element_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] out_x,
  output logic signed      [31:0] out_y,
  output logic signed      [31:0] out_z,
  output logic             [1:0]  status
);

  // column sums fit CW signed bits; magnitudes fit MW unsigned bits
  localparam int CW    = 66 - FRAC_BITS;
  localparam int MW    = CW;
  localparam int SH    = 32 - FRAC_BITS;
  localparam int QB    = 32;
  localparam int DIV0  = 6;
  localparam int NS    = DIV0 + QB + 1;
  localparam int OUTS  = NS - 1;
  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  // ---------------- handshake and stage control ----------------
  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[OUTS];

  logic accept;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= accept && (action == ACT_TRANSFORM);
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ---------------- matrix store ----------------
  logic signed [31:0] mat [0:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= ((i % 5) == 0) ? ONE : 32'd0;
      end
    end else if (accept && (action == ACT_LOAD)) begin
      mat[element_index] <= element_value;
    end
  end

  // ---------------- stage 0: capture point and matrix snapshot ----------------
  // snapshot keeps a later load from reaching a transform still in flight
  logic signed [31:0] s0_pt  [0:2];
  logic signed [31:0] s0_mat [0:15];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_pt[0] <= point_x;
      s0_pt[1] <= point_y;
      s0_pt[2] <= point_z;
      for (int i = 0; i < 16; i++) begin
        s0_mat[i] <= mat[i];
      end
    end
  end

  // ---------------- stage 1: twelve exact products ----------------
  logic signed [63:0] s1_prod [0:2][0:3];
  logic signed [31:0] s1_trans [0:3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 4; j++) begin
          s1_prod[r][j] <= 64'(s0_pt[r]) * 64'(s0_mat[r*4+j]);
        end
      end
      for (int j = 0; j < 4; j++) begin
        s1_trans[j] <= s0_mat[12+j];
      end
    end
  end

  // ---------------- stage 2: floor shift and pairwise sums ----------------
  logic signed [CW-1:0] s2_a [0:3];
  logic signed [CW-1:0] s2_b [0:3];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int j = 0; j < 4; j++) begin
        s2_a[j] <= CW'(s1_prod[0][j] >>> FRAC_BITS) + CW'(s1_prod[1][j] >>> FRAC_BITS);
        s2_b[j] <= CW'(s1_prod[2][j] >>> FRAC_BITS) + CW'(s1_trans[j]);
      end
    end
  end

  // ---------------- stage 3: column sums ----------------
  logic signed [CW-1:0] s3_col [0:3];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int j = 0; j < 4; j++) begin
        s3_col[j] <= s2_a[j] + s2_b[j];
      end
    end
  end

  // ---------------- stage 4: signs, magnitudes, zero w ----------------
  logic [MW-1:0] s4_n [0:2];
  logic          s4_neg [0:2];
  logic [MW-1:0] s4_d;
  logic          s4_zero;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int j = 0; j < 3; j++) begin
        s4_neg[j] <= s3_col[j][CW-1] ^ s3_col[3][CW-1];
        s4_n[j]   <= s3_col[j][CW-1] ? MW'(-s3_col[j]) : MW'(s3_col[j]);
      end
      s4_d    <= s3_col[3][CW-1] ? MW'(-s3_col[3]) : MW'(s3_col[3]);
      s4_zero <= (s3_col[3] == '0);
    end
  end

  // ---------------- stage 5 and divide stages ----------------
  // dv_*[0] is stage 5; dv_*[s+1] holds the state after quotient step s
  logic [MW-1:0] dv_rem  [0:QB][0:2];
  logic [31:0]   dv_q    [0:QB][0:2];
  logic [31:0]   dv_low  [0:QB][0:2];
  logic          dv_neg  [0:QB][0:2];
  logic          dv_ov   [0:QB][0:2];
  logic [MW-1:0] dv_den  [0:QB];
  logic          dv_zero [0:QB];

  // quotient reaches 2^32 exactly when n >= d * 2^(32-FRAC_BITS)
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int j = 0; j < 3; j++) begin
        dv_ov[0][j]  <= ((MW+SH)'(s4_n[j]) >= {s4_d, {SH{1'b0}}});
        dv_rem[0][j] <= s4_n[j] >> SH;
        dv_low[0][j] <= {s4_n[j][SH-1:0], {FRAC_BITS{1'b0}}};
        dv_q[0][j]   <= '0;
        dv_neg[0][j] <= s4_neg[j];
      end
      dv_den[0]  <= s4_d;
      dv_zero[0] <= s4_zero;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [MW-1:0] rem_next [0:2];
    logic          qb       [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_lane
      vtpd_div_step #(
        .MW(MW)
      ) u_step (
        .rem_in (dv_rem[s][j]),
        .den    (dv_den[s]),
        .bit_in (dv_low[s][j][31]),
        .rem_out(rem_next[j]),
        .q_bit  (qb[j])
      );
    end

    always_ff @(posedge clk) begin
      if (adv[DIV0+s]) begin
        for (int j = 0; j < 3; j++) begin
          dv_rem[s+1][j] <= rem_next[j];
          dv_q[s+1][j]   <= {dv_q[s][j][30:0], qb[j]};
          dv_low[s+1][j] <= {dv_low[s][j][30:0], 1'b0};
          dv_neg[s+1][j] <= dv_neg[s][j];
          dv_ov[s+1][j]  <= dv_ov[s][j];
        end
        dv_den[s+1]  <= dv_den[s];
        dv_zero[s+1] <= dv_zero[s];
      end
    end
  end

  // ---------------- output stage: sign, saturate, status ----------------
  logic [31:0] res  [0:2];
  logic        sat  [0:2];
  logic [1:0]  status_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dv_neg[QB][j]) begin
        sat[j] = dv_ov[QB][j] || (dv_q[QB][j] > SAT_NEG);
        res[j] = sat[j] ? SAT_NEG : (32'd0 - dv_q[QB][j]);
      end else begin
        sat[j] = dv_ov[QB][j] || dv_q[QB][j][31];
        res[j] = sat[j] ? SAT_POS : dv_q[QB][j];
      end
    end
    if (dv_zero[QB]) begin
      status_next = STATUS_WZERO;
    end else if (sat[0] || sat[1] || sat[2]) begin
      status_next = STATUS_SAT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // zero w forces all three coordinates to zero
  always_ff @(posedge clk) begin
    if (adv[OUTS]) begin
      out_x  <= dv_zero[QB] ? 32'sd0 : $signed(res[0]);
      out_y  <= dv_zero[QB] ? 32'sd0 : $signed(res[1]);
      out_z  <= dv_zero[QB] ? 32'sd0 : $signed(res[2]);
      status <= status_next;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_vertex_transform_perspective_divide.sv
// Testbench for the vertex transform and perspective divide block.
module tb_vertex_transform_perspective_divide;
  import vtpd_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct {
    logic              action;
    logic [3:0]        element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } request_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         st;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_LOAD;
  logic [3:0] element_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0] status;

  vertex_transform_perspective_divide u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .element_index(element_index), .element_value(element_value),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
  );

  request_t pending_requests[$];
  vertex_t  expected_vertices[$];
  logic signed [31:0] matrix_copy[16];
  request_t on_port;
  int in_gap = 0;
  int out_gap = 0;
  int errors = 0;

  // Clock generator; the single reset pulse is released in the report block below.
  initial begin
    forever #6 clk = ~clk;
  end

  // Scale a fixed-point product back down; >>> on a signed value floors.
  function automatic logic signed [63:0] scaled_product(logic signed [31:0] a,
                                                        logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FRAC;
  endfunction

  // Divide num by w with the fraction re-applied; truncate, then clamp to 32 bits.
  function automatic logic signed [31:0] clamped_quotient(logic signed [63:0] num,
                                                          logic signed [63:0] w,
                                                          ref logic clipped);
    logic neg;
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    neg = (num < 0) != (w < 0);
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (w < 0) ? 128'(-w) : 128'(w);
    q = (n << FRAC) / d;
    if (!neg && q > 128'h7FFF_FFFF) begin
      clipped = 1'b1;
      return SAT_POS;
    end
    if (neg && q > 128'h8000_0000) begin
      clipped = 1'b1;
      return SAT_NEG;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // Apply one accepted request to the matrix copy; queue the vertex it yields.
  function automatic void transform_vertex(request_t r);
    logic signed [63:0] col[4];
    logic clipped;
    vertex_t v;
    if (r.action == ACT_LOAD) begin
      matrix_copy[r.element_index] = r.element_value;
      return;
    end
    for (int j = 0; j < 4; j++)
      col[j] = scaled_product(r.point_x, matrix_copy[j]) +
               scaled_product(r.point_y, matrix_copy[4 + j]) +
               scaled_product(r.point_z, matrix_copy[8 + j]) +
               64'(matrix_copy[12 + j]);
    clipped = 1'b0;
    if (col[3] == 0) begin
      v.x = '0; v.y = '0; v.z = '0; v.st = STATUS_WZERO;
    end else begin
      v.x = clamped_quotient(col[0], col[3], clipped);
      v.y = clamped_quotient(col[1], col[3], clipped);
      v.z = clamped_quotient(col[2], col[3], clipped);
      v.st = clipped ? STATUS_SAT : STATUS_OK;
    end
    expected_vertices.push_back(v);
  endfunction

  // Mix of extremes, full-range noise and small well-behaved values.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd65536;
        endcase
      end
      1: return $urandom;
      default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  function automatic void add_load(int idx, logic signed [31:0] val);
    request_t r;
    r.action = ACT_LOAD;
    r.element_index = idx[3:0];
    r.element_value = val;
    r.point_x = $urandom; r.point_y = $urandom; r.point_z = $urandom;
    pending_requests.push_back(r);
  endfunction

  function automatic void add_point(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z);
    request_t r;
    r.action = ACT_TRANSFORM;
    r.element_index = $urandom;
    r.element_value = $urandom;
    r.point_x = x; r.point_y = y; r.point_z = z;
    pending_requests.push_back(r);
  endfunction

  function automatic void add_identity();
    for (int i = 0; i < 16; i++)
      add_load(i, (i % 5 == 0) ? 32'sd65536 : 32'sd0);
  endfunction

  // Fill the request queue: a directed opening, then random batches.
  initial begin
    add_point(0, 0, 0);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    // w collapses to zero at the origin
    add_load(15, 0);
    add_point(0, 0, 0);
    // tiny w drives every quotient to its clamp, both signs
    add_load(15, 1);
    add_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000);
    // perspective row: w follows z
    add_load(15, 32'sh0001_0000);
    add_load(11, 32'sh0000_8000);
    add_point(32'sh0004_0000, -32'sh0002_0000, 32'sh0002_0000);
    add_load(3, 32'sh8000_0000);
    add_point(-32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_load(12, 32'sh7FFF_FFFF);
    add_load(0, 32'sh8000_0000);
    add_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    add_identity();

    while (pending_requests.size() < 1550) begin
      case ($urandom_range(0, 19))
        0: add_identity();
        1, 2: begin
          repeat ($urandom_range(1, 6)) add_load($urandom_range(0, 15), pick_value());
        end
        3: add_load(15, pick_value());
        default: add_point(pick_value(), pick_value(), pick_value());
      endcase
    end
  end

  // Driver: advance the request stream, predicting each request as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      for (int i = 0; i < 16; i++)
        matrix_copy[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) transform_vertex(on_port);
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 200 && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 15) - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        on_port = pending_requests.pop_front();
        in_valid <= 1'b1;
        action <= on_port.action;
        element_index <= on_port.element_index;
        element_value <= on_port.element_value;
        point_x <= on_port.point_x;
        point_y <= on_port.point_y;
        point_z <= on_port.point_z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each delivered vertex against the oldest prediction.
  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected vertex x=%h y=%h z=%h st=%0d",
                   $time, out_x, out_y, out_z, status);
          errors++;
        end else begin
          want = expected_vertices.pop_front();
          if (out_x !== want.x) begin
            $display("%0t: out_x expected %h actual %h", $time, want.x, out_x);
            errors++;
          end
          if (out_y !== want.y) begin
            $display("%0t: out_y expected %h actual %h", $time, want.y, out_y);
            errors++;
          end
          if (out_z !== want.z) begin
            $display("%0t: out_z expected %h actual %h", $time, want.z, out_z);
            errors++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            errors++;
          end
        end
      end
      // hold stall in bursts; drop it for good near the end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (pending_requests.size() > 200 && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Release reset, drain, then report.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (pending_requests.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Hard limit on run length.
  initial begin
    #(12 * 3_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/vtpd_pkg.sv
rtl/vtpd_div_step.sv
rtl/vertex_transform_perspective_divide.sv
tb/sv/tb_vertex_transform_perspective_divide.sv
